// File: rtl/sgr_pkg.sv
// Shared types, byte and rendition codes for the SGR attribute parser.
package sgr_pkg;

	localparam int PARAM_BITS_DEF = 10;
	localparam int SGR_NUM_W      = 16;   // widest parameter accumulator
	localparam int BAD_CODE_W     = 10;
	localparam int COL_W          = 5;

	localparam logic [BAD_CODE_W-1:0] BAD_CODE_MAX = '1;

	// Bytes of interest
	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_ESC   = 8'h1B;
	localparam logic [7:0] BYTE_LBRK  = 8'h5B;
	localparam logic [7:0] BYTE_SEMI  = 8'h3B;
	localparam logic [7:0] BYTE_M     = 8'h6D;
	localparam logic [7:0] BYTE_ZERO  = 8'h30;
	localparam logic [7:0] BYTE_ONE   = 8'h31;
	localparam logic [7:0] BYTE_NINE  = 8'h39;

	// Result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_BAD  = 1'b1;

	// Weights
	localparam logic [1:0] WEIGHT_NORMAL = 2'd0;
	localparam logic [1:0] WEIGHT_BOLD   = 2'd1;
	localparam logic [1:0] WEIGHT_LIGHT  = 2'd2;

	// Colour indices
	localparam logic [COL_W-1:0] COL_BRIGHT_BASE = 5'd8;
	localparam logic [COL_W-1:0] COL_UNSET       = 5'd16;
	localparam logic [COL_W-1:0] COL_SYSFG       = 5'd17;
	localparam logic [COL_W-1:0] COL_SYSBG       = 5'd18;

	// Rendition codes
	localparam logic [SGR_NUM_W-1:0] SGR_BOLD       = 16'd1;
	localparam logic [SGR_NUM_W-1:0] SGR_LIGHT      = 16'd2;
	localparam logic [SGR_NUM_W-1:0] SGR_ITALIC     = 16'd3;
	localparam logic [SGR_NUM_W-1:0] SGR_ULINE      = 16'd4;
	localparam logic [SGR_NUM_W-1:0] SGR_SWAP       = 16'd7;
	localparam logic [SGR_NUM_W-1:0] SGR_ULINE_ALT  = 16'd21;
	localparam logic [SGR_NUM_W-1:0] SGR_NORMAL     = 16'd22;
	localparam logic [SGR_NUM_W-1:0] SGR_ULINE_OFF  = 16'd24;
	localparam logic [SGR_NUM_W-1:0] SGR_SWAP_ALT   = 16'd27;
	localparam logic [SGR_NUM_W-1:0] SGR_FG_DARK    = 16'd30;
	localparam logic [SGR_NUM_W-1:0] SGR_FG_SYS     = 16'd39;
	localparam logic [SGR_NUM_W-1:0] SGR_BG_DARK    = 16'd40;
	localparam logic [SGR_NUM_W-1:0] SGR_BG_SYS     = 16'd49;
	localparam logic [SGR_NUM_W-1:0] SGR_FG_BRIGHT  = 16'd90;
	localparam logic [SGR_NUM_W-1:0] SGR_FG_SYS_ALT = 16'd99;
	localparam logic [SGR_NUM_W-1:0] SGR_BG_BRIGHT  = 16'd100;
	localparam logic [SGR_NUM_W-1:0] SGR_BG_SYS_ALT = 16'd109;
	localparam logic [SGR_NUM_W-1:0] SGR_COL_SPAN   = 16'd7;   // last offset of a colour run

	typedef struct packed {
		logic [1:0]       weight;
		logic             italic;
		logic             underline;
		logic [COL_W-1:0] fg;
		logic [COL_W-1:0] bg;
	} attr_t;

	localparam attr_t ATTR_RESET = '{
		weight:    WEIGHT_NORMAL,
		italic:    1'b0,
		underline: 1'b0,
		fg:        COL_UNSET,
		bg:        COL_UNSET
	};

	typedef struct packed {
		logic                  kind;
		logic [7:0]            char_code;
		attr_t                 attr;
		logic [BAD_CODE_W-1:0] bad_code;
	} result_t;

endpackage

// File: rtl/ansi_sgr_attribute_parser.sv
// Top level of the SGR attribute parser: input register, engine, result register.
//
// Takes one byte per item and turns a text stream with embedded ESC [ ... m
// rendition sequences into printable characters tagged with the current
// weight, italic, underline and colour attributes, plus error items for
// unknown rendition codes. The block takes one item every cycle unless a
// result waits on a full output register: a byte sits in the input register,
// the engine decides its effect in shallow logic (a compare chain on the
// finished parameter and a multiply-by-ten add for the accumulator) and any
// result lands in the output register, from which it can then be taken.
// Bytes that produce nothing (escape bytes, digits, CR, NUL, separators that
// close a known code) never wait on the output side; a byte that produces a
// result waits only while the output register is full and not being taken,
// and in_ready follows out_ready combinationally in that case. Internal
// states: scanning text, waiting for '[', waiting for the first digit and
// accumulating parameters; the accumulator is PARAM_BITS wide and saturates,
// and bad_code reports the value clamped to 1023.
module ansi_sgr_attribute_parser #(
	parameter int PARAM_BITS = sgr_pkg::PARAM_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// byte input
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	// result output
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] char_code,
	output logic [1:0] weight,
	output logic       italic,
	output logic       underline,
	output logic [4:0] fg_color,
	output logic [4:0] bg_color,
	output logic [9:0] bad_code
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             step;
	logic             emit;
	sgr_pkg::result_t eng_result;
	sgr_pkg::result_t res_q;
	logic             out_valid_q;

	sgr_engine #(.PARAM_BITS(PARAM_BITS)) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.emit    (emit),
		.result  (eng_result)
	);

	// The byte in front moves on when it yields nothing or the result slot frees up.
	assign step     = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= in_byte;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit)
			res_q <= eng_result;
	end

	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign char_code = res_q.char_code;
	assign weight    = res_q.attr.weight;
	assign italic    = res_q.attr.italic;
	assign underline = res_q.attr.underline;
	assign fg_color  = res_q.attr.fg;
	assign bg_color  = res_q.attr.bg;
	assign bad_code  = res_q.bad_code;

	// A character item never carries a dropped byte or an error code.
	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sgr_pkg::KIND_CHAR |->
			bad_code == '0 && char_code != sgr_pkg::BYTE_NUL && char_code != sgr_pkg::BYTE_CR)
		else $error("character item carries dropped byte or error code");

	// An error item always names a nonzero code and no character.
	a_bad_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sgr_pkg::KIND_BAD |-> bad_code != '0 && char_code == '0)
		else $error("error item without code");

	// Colour indices and the weight stay within the defined encoding.
	a_colour_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fg_color <= sgr_pkg::COL_SYSBG && bg_color <= sgr_pkg::COL_SYSBG
			&& weight <= sgr_pkg::WEIGHT_LIGHT)
		else $error("attribute out of range");

	// A new result is only loaded once the previous one has gone.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(res_q))
		else $error("result register overwritten while held");

endmodule

// File: rtl/sgr_code_decode.sv
// Applies one finished rendition parameter to the attribute set.
module sgr_code_decode #(
	parameter int PARAM_BITS = sgr_pkg::PARAM_BITS_DEF
) (
	input  logic [PARAM_BITS-1:0] num,
	input  logic                  num_bad,
	input  sgr_pkg::attr_t        attr_in,
	output sgr_pkg::attr_t        attr_out,
	output logic                  unknown
);

	logic [sgr_pkg::SGR_NUM_W-1:0] n;
	logic [sgr_pkg::SGR_NUM_W-1:0] off_fg_d, off_fg_b, off_bg_d, off_bg_b;

	assign n        = sgr_pkg::SGR_NUM_W'(num);
	assign off_fg_d = n - sgr_pkg::SGR_FG_DARK;
	assign off_fg_b = n - sgr_pkg::SGR_FG_BRIGHT;
	assign off_bg_d = n - sgr_pkg::SGR_BG_DARK;
	assign off_bg_b = n - sgr_pkg::SGR_BG_BRIGHT;

	always_comb begin
		attr_out = attr_in;
		unknown  = 1'b0;
		if (num_bad || n == '0) begin
			// non-numeric or empty: ignored
		end else if (n >= sgr_pkg::SGR_FG_DARK && off_fg_d <= sgr_pkg::SGR_COL_SPAN) begin
			attr_out.fg = sgr_pkg::COL_W'(off_fg_d);
		end else if (n >= sgr_pkg::SGR_FG_BRIGHT && off_fg_b <= sgr_pkg::SGR_COL_SPAN) begin
			attr_out.fg = sgr_pkg::COL_W'(off_fg_b) + sgr_pkg::COL_BRIGHT_BASE;
		end else if (n >= sgr_pkg::SGR_BG_DARK && off_bg_d <= sgr_pkg::SGR_COL_SPAN) begin
			attr_out.bg = sgr_pkg::COL_W'(off_bg_d);
		end else if (n >= sgr_pkg::SGR_BG_BRIGHT && off_bg_b <= sgr_pkg::SGR_COL_SPAN) begin
			attr_out.bg = sgr_pkg::COL_W'(off_bg_b) + sgr_pkg::COL_BRIGHT_BASE;
		end else begin
			case (n)
				sgr_pkg::SGR_BOLD:      attr_out.weight = sgr_pkg::WEIGHT_BOLD;
				sgr_pkg::SGR_LIGHT:     attr_out.weight = sgr_pkg::WEIGHT_LIGHT;
				sgr_pkg::SGR_NORMAL:    attr_out.weight = sgr_pkg::WEIGHT_NORMAL;
				sgr_pkg::SGR_ITALIC:    attr_out.italic = 1'b1;
				sgr_pkg::SGR_ULINE,
				sgr_pkg::SGR_ULINE_ALT: attr_out.underline = 1'b1;
				sgr_pkg::SGR_ULINE_OFF: attr_out.underline = 1'b0;
				sgr_pkg::SGR_SWAP,
				sgr_pkg::SGR_SWAP_ALT: begin
					attr_out.fg = attr_in.bg;
					attr_out.bg = attr_in.fg;
				end
				sgr_pkg::SGR_FG_SYS,
				sgr_pkg::SGR_FG_SYS_ALT: attr_out.fg = sgr_pkg::COL_SYSFG;
				sgr_pkg::SGR_BG_SYS,
				sgr_pkg::SGR_BG_SYS_ALT: attr_out.bg = sgr_pkg::COL_SYSBG;
				default:                 unknown = 1'b1;
			endcase
		end
	end

endmodule

// File: rtl/sgr_engine.sv
// Sequence state machine, parameter accumulator and attribute registers.
module sgr_engine #(
	parameter int PARAM_BITS = sgr_pkg::PARAM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,      // consume the byte in front
	input  logic [7:0]        byte_in,
	output logic              emit,      // this byte yields a result
	output sgr_pkg::result_t  result
);

	typedef enum logic [3:0] {
		PH_SCAN    = 4'b0001,
		PH_BRACKET = 4'b0010,
		PH_FIRST   = 4'b0100,
		PH_ACCUM   = 4'b1000
	} phase_t;

	localparam int ACC_W = PARAM_BITS + 4;
	localparam logic [ACC_W-1:0] MAXV = {4'b0000, {PARAM_BITS{1'b1}}};

	phase_t                phase_q, phase_d;
	logic [PARAM_BITS-1:0] pval_q, pval_d;
	logic                  pbad_q, pbad_d;
	sgr_pkg::attr_t        attr_q, attr_d;

	sgr_pkg::attr_t        dec_attr;
	logic                  dec_unknown;
	logic                  is_digit;
	logic [3:0]            digit;
	logic [ACC_W-1:0]      acc;
	logic [PARAM_BITS-1:0] acc_sat;
	logic [sgr_pkg::SGR_NUM_W-1:0] pv_wide;
	logic [sgr_pkg::BAD_CODE_W-1:0] bad_sat;

	sgr_code_decode #(.PARAM_BITS(PARAM_BITS)) u_decode (
		.num      (pval_q),
		.num_bad  (pbad_q),
		.attr_in  (attr_q),
		.attr_out (dec_attr),
		.unknown  (dec_unknown)
	);

	assign is_digit = byte_in >= sgr_pkg::BYTE_ZERO && byte_in <= sgr_pkg::BYTE_NINE;
	assign digit    = 4'(byte_in - sgr_pkg::BYTE_ZERO);

	// value * 10 + digit, saturating
	assign acc     = ACC_W'({pval_q, 3'b000}) + ACC_W'({pval_q, 1'b0}) + ACC_W'(digit);
	assign acc_sat = (acc > MAXV) ? '1 : PARAM_BITS'(acc);

	assign pv_wide = sgr_pkg::SGR_NUM_W'(pval_q);
	assign bad_sat = (pv_wide > sgr_pkg::SGR_NUM_W'(sgr_pkg::BAD_CODE_MAX))
		? sgr_pkg::BAD_CODE_MAX : sgr_pkg::BAD_CODE_W'(pv_wide);

	always_comb begin
		phase_d          = phase_q;
		pval_d           = pval_q;
		pbad_d           = pbad_q;
		attr_d           = attr_q;
		emit             = 1'b0;
		result.kind      = sgr_pkg::KIND_CHAR;
		result.char_code = byte_in;
		result.attr      = attr_q;
		result.bad_code  = '0;
		case (phase_q)
			PH_SCAN: begin
				if (byte_in == sgr_pkg::BYTE_ESC) begin
					phase_d = PH_BRACKET;
				end else if (byte_in != sgr_pkg::BYTE_CR && byte_in != sgr_pkg::BYTE_NUL) begin
					emit = 1'b1;
				end
			end
			PH_BRACKET: begin
				phase_d = (byte_in == sgr_pkg::BYTE_LBRK) ? PH_FIRST : PH_SCAN;
				pval_d  = '0;
				pbad_d  = 1'b0;
			end
			PH_FIRST: begin
				if (byte_in >= sgr_pkg::BYTE_ONE && byte_in <= sgr_pkg::BYTE_NINE) begin
					pval_d  = PARAM_BITS'(digit);
					pbad_d  = 1'b0;
					phase_d = PH_ACCUM;
				end else if (byte_in == sgr_pkg::BYTE_M) begin
					attr_d  = sgr_pkg::ATTR_RESET;
					phase_d = PH_SCAN;
				end
			end
			PH_ACCUM: begin
				if (byte_in == sgr_pkg::BYTE_SEMI || byte_in == sgr_pkg::BYTE_M) begin
					attr_d           = dec_attr;
					pval_d           = '0;
					pbad_d           = 1'b0;
					emit             = dec_unknown;
					result.kind      = sgr_pkg::KIND_BAD;
					result.char_code = '0;
					result.bad_code  = bad_sat;
					if (byte_in == sgr_pkg::BYTE_M)
						phase_d = PH_SCAN;
				end else if (is_digit) begin
					pval_d = acc_sat;
				end else begin
					pbad_d = 1'b1;
				end
			end
			default: phase_d = PH_SCAN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			pval_q  <= '0;
			pbad_q  <= 1'b0;
			attr_q  <= sgr_pkg::ATTR_RESET;
		end else if (step) begin
			phase_q <= phase_d;
			pval_q  <= pval_d;
			pbad_q  <= pbad_d;
			attr_q  <= attr_d;
		end
	end

endmodule

// File: test/ansi_sgr_attribute_parser_tb.sv
// Self-checking testbench for the SGR attribute parser: stimulus, predictor, scoreboard.
module ansi_sgr_attribute_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PARAM_BITS   = sgr_pkg::PARAM_BITS_DEF;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;      // result register sits behind the input register

	// parser position within the byte stream
	typedef enum logic [3:0] {
		PH_TEXT  = 4'b0001,   // plain text
		PH_ESC   = 4'b0010,   // ESC seen, want '['
		PH_FIRST = 4'b0100,   // inside ESC [, no digit yet
		PH_PARAM = 4'b1000    // accumulating a parameter
	} scan_phase_t;

	// Attribute predictor plus the queue of rendition results still owed by the block
	class sgr_scoreboard;
		scan_phase_t      ph;
		int unsigned      acc;
		bit               acc_bad;
		sgr_pkg::attr_t   attr;
		sgr_pkg::result_t owed_q[$];
		int               errors;

		function new();
			ph      = PH_TEXT;
			acc     = 0;
			acc_bad = 1'b0;
			attr    = sgr_pkg::ATTR_RESET;
			errors  = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t ns: %s", $time, msg);
		endfunction

		function sgr_pkg::result_t make_result(logic k, logic [7:0] c, int unsigned code);
			sgr_pkg::result_t r;
			r.kind      = k;
			r.char_code = c;
			r.attr      = attr;
			r.bad_code  = (code > sgr_pkg::BAD_CODE_MAX) ? sgr_pkg::BAD_CODE_MAX
				: sgr_pkg::BAD_CODE_W'(code);
			return r;
		endfunction

		// a finished parameter either changes the attributes or owes an error item
		function void apply_code();
			int unsigned n;
			bit          junk;
			logic [sgr_pkg::COL_W-1:0] tmp;
			n       = acc;
			junk    = acc_bad;
			acc     = 0;
			acc_bad = 1'b0;
			if (junk || n == 0)
				return;
			if (n >= sgr_pkg::SGR_FG_DARK
					&& n <= sgr_pkg::SGR_FG_DARK + sgr_pkg::SGR_COL_SPAN) begin
				attr.fg = sgr_pkg::COL_W'(n - sgr_pkg::SGR_FG_DARK);
			end else if (n >= sgr_pkg::SGR_FG_BRIGHT
					&& n <= sgr_pkg::SGR_FG_BRIGHT + sgr_pkg::SGR_COL_SPAN) begin
				attr.fg = sgr_pkg::COL_W'(sgr_pkg::COL_BRIGHT_BASE + (n - sgr_pkg::SGR_FG_BRIGHT));
			end else if (n >= sgr_pkg::SGR_BG_DARK
					&& n <= sgr_pkg::SGR_BG_DARK + sgr_pkg::SGR_COL_SPAN) begin
				attr.bg = sgr_pkg::COL_W'(n - sgr_pkg::SGR_BG_DARK);
			end else if (n >= sgr_pkg::SGR_BG_BRIGHT
					&& n <= sgr_pkg::SGR_BG_BRIGHT + sgr_pkg::SGR_COL_SPAN) begin
				attr.bg = sgr_pkg::COL_W'(sgr_pkg::COL_BRIGHT_BASE + (n - sgr_pkg::SGR_BG_BRIGHT));
			end else begin
				case (n)
					sgr_pkg::SGR_BOLD:   attr.weight = sgr_pkg::WEIGHT_BOLD;
					sgr_pkg::SGR_LIGHT:  attr.weight = sgr_pkg::WEIGHT_LIGHT;
					sgr_pkg::SGR_NORMAL: attr.weight = sgr_pkg::WEIGHT_NORMAL;
					sgr_pkg::SGR_ITALIC: attr.italic = 1'b1;
					sgr_pkg::SGR_ULINE, sgr_pkg::SGR_ULINE_ALT: attr.underline = 1'b1;
					sgr_pkg::SGR_ULINE_OFF:                     attr.underline = 1'b0;
					sgr_pkg::SGR_SWAP, sgr_pkg::SGR_SWAP_ALT: begin
						tmp     = attr.fg;
						attr.fg = attr.bg;
						attr.bg = tmp;
					end
					sgr_pkg::SGR_FG_SYS, sgr_pkg::SGR_FG_SYS_ALT: attr.fg = sgr_pkg::COL_SYSFG;
					sgr_pkg::SGR_BG_SYS, sgr_pkg::SGR_BG_SYS_ALT: attr.bg = sgr_pkg::COL_SYSBG;
					default: owed_q.push_back(make_result(sgr_pkg::KIND_BAD, 8'h00, n));
				endcase
			end
		endfunction

		// called once per accepted byte
		function void note_byte(logic [7:0] b);
			case (ph)
				PH_TEXT: begin
					if (b == sgr_pkg::BYTE_ESC)
						ph = PH_ESC;
					else if (b != sgr_pkg::BYTE_CR && b != sgr_pkg::BYTE_NUL)
						owed_q.push_back(make_result(sgr_pkg::KIND_CHAR, b, 0));
				end
				PH_ESC: begin
					ph      = (b == sgr_pkg::BYTE_LBRK) ? PH_FIRST : PH_TEXT;
					acc     = 0;
					acc_bad = 1'b0;
				end
				PH_FIRST: begin
					if (b >= sgr_pkg::BYTE_ONE && b <= sgr_pkg::BYTE_NINE) begin
						acc     = b - sgr_pkg::BYTE_ZERO;
						acc_bad = 1'b0;
						ph      = PH_PARAM;
					end else if (b == sgr_pkg::BYTE_M) begin
						attr = sgr_pkg::ATTR_RESET;
						ph   = PH_TEXT;
					end
				end
				default: begin
					if (b == sgr_pkg::BYTE_SEMI) begin
						apply_code();
					end else if (b == sgr_pkg::BYTE_M) begin
						ph = PH_TEXT;
						apply_code();
					end else if (b >= sgr_pkg::BYTE_ZERO && b <= sgr_pkg::BYTE_NINE) begin
						acc = acc * 10 + (b - sgr_pkg::BYTE_ZERO);
						if (acc > (1 << PARAM_BITS) - 1)
							acc = (1 << PARAM_BITS) - 1;
					end else begin
						acc_bad = 1'b1;
					end
				end
			endcase
		endfunction

		function void check_result(sgr_pkg::result_t got);
			sgr_pkg::result_t want;
			bit               ok;
			if (owed_q.size() == 0) begin
				flag($sformatf("result with nothing owed: kind=%0d char=%02h bad=%0d",
					got.kind, got.char_code, got.bad_code));
				return;
			end
			want = owed_q.pop_front();
			ok = (got.kind === want.kind) && (got.char_code === want.char_code) &&
				(got.attr.weight === want.attr.weight) &&
				(got.attr.italic === want.attr.italic) &&
				(got.attr.underline === want.attr.underline) &&
				(got.attr.fg === want.attr.fg) && (got.attr.bg === want.attr.bg) &&
				(got.bad_code === want.bad_code);
			if (!ok)
				flag({$sformatf("mismatch: exp kind=%0d chr=%02h wt=%0d it=%0d ul=%0d fg=%0d bg=%0d bad=%0d",
					want.kind, want.char_code, want.attr.weight, want.attr.italic,
					want.attr.underline, want.attr.fg, want.attr.bg, want.bad_code),
					$sformatf(" / got kind=%0d chr=%02h wt=%0d it=%0d ul=%0d fg=%0d bg=%0d bad=%0d",
					got.kind, got.char_code, got.attr.weight, got.attr.italic,
					got.attr.underline, got.attr.fg, got.attr.bg, got.bad_code)});
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte   = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       kind;
	logic [7:0] char_code;
	logic [1:0] weight;
	logic       italic;
	logic       underline;
	logic [4:0] fg_color;
	logic [4:0] bg_color;
	logic [9:0] bad_code;

	sgr_scoreboard sb = new();

	int sender_idle_pct = 0;   // chance in a hundred of an empty cycle before each item
	int recv_stall_pct  = 0;   // chance in a hundred of out_ready low on a cycle
	int bytes_sent      = 0;

	ansi_sgr_attribute_parser #(.PARAM_BITS(PARAM_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.char_code (char_code),
		.weight    (weight),
		.italic    (italic),
		.underline (underline),
		.fg_color  (fg_color),
		.bg_color  (bg_color),
		.bad_code  (bad_code)
	);

	always #1 clk = ~clk;

	// Result side: sample on the edge (pre-edge values), then pick next out_ready.
	always @(posedge clk) begin
		sgr_pkg::result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.kind           = kind;
			got.char_code      = char_code;
			got.attr.weight    = weight;
			got.attr.italic    = italic;
			got.attr.underline = underline;
			got.attr.fg        = fg_color;
			got.attr.bg        = bg_color;
			got.bad_code       = bad_code;
			sb.check_result(got);
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: a hung handshake or a missing result ends here.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL ansi_sgr_attribute_parser");
		$finish;
	end

	// One item onto the byte channel. Always entered at a rising edge; valid
	// stays high with the byte held until the edge where in_ready is seen.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Hold off the sender until every owed result has come out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic int unsigned pick_known_code();
		int unsigned fixed_codes[13] = '{sgr_pkg::SGR_BOLD, sgr_pkg::SGR_LIGHT,
			sgr_pkg::SGR_ITALIC, sgr_pkg::SGR_ULINE, sgr_pkg::SGR_SWAP,
			sgr_pkg::SGR_ULINE_ALT, sgr_pkg::SGR_NORMAL, sgr_pkg::SGR_ULINE_OFF,
			sgr_pkg::SGR_SWAP_ALT, sgr_pkg::SGR_FG_SYS, sgr_pkg::SGR_BG_SYS,
			sgr_pkg::SGR_FG_SYS_ALT, sgr_pkg::SGR_BG_SYS_ALT};
		int unsigned colour_bases[4] = '{sgr_pkg::SGR_FG_DARK, sgr_pkg::SGR_FG_BRIGHT,
			sgr_pkg::SGR_BG_DARK, sgr_pkg::SGR_BG_BRIGHT};
		if ($urandom_range(1))
			return colour_bases[$urandom_range(3)] + $urandom_range(sgr_pkg::SGR_COL_SPAN);
		return fixed_codes[$urandom_range(12)];
	endfunction

	// any byte that is not a digit, a separator or the final 'm'; ESC often
	function automatic logic [7:0] pick_junk();
		logic [7:0] j;
		if ($urandom_range(2) == 0)
			return sgr_pkg::BYTE_ESC;
		do j = 8'($urandom_range(255));
		while ((j >= sgr_pkg::BYTE_ZERO && j <= sgr_pkg::BYTE_NINE) ||
			j == sgr_pkg::BYTE_SEMI || j == sgr_pkg::BYTE_M);
		return j;
	endfunction

	// One parameter body, no separator.
	task automatic send_param();
		int r;
		int len;
		r = $urandom_range(99);
		if ($urandom_range(9) == 0)
			send_byte(sgr_pkg::BYTE_ZERO);           // leading zero
		if (r < 60) begin
			send_string($sformatf("%0d", pick_known_code()));
		end else if (r < 78) begin
			send_string($sformatf("%0d", $urandom_range(130)));
		end else if (r < 86) begin
			send_string($sformatf("%0d", $urandom_range(1200)));
		end else if (r < 92) begin
			// long digit run, may saturate the accumulator
			len = $urandom_range(4, 7);
			send_byte(8'($urandom_range(sgr_pkg::BYTE_ONE, sgr_pkg::BYTE_NINE)));
			repeat (len - 1)
				send_byte(8'($urandom_range(sgr_pkg::BYTE_ZERO, sgr_pkg::BYTE_NINE)));
		end else if (r < 96) begin
			// empty parameter
		end else begin
			// digit then a stray byte: the whole parameter is dropped
			send_byte(8'($urandom_range(sgr_pkg::BYTE_ONE, sgr_pkg::BYTE_NINE)));
			send_byte(pick_junk());
			if ($urandom_range(1))
				send_byte(8'($urandom_range(sgr_pkg::BYTE_ZERO, sgr_pkg::BYTE_NINE)));
		end
	endtask

	task automatic send_sgr_sequence();
		int nparams;
		send_byte(sgr_pkg::BYTE_ESC);
		send_byte(sgr_pkg::BYTE_LBRK);
		if ($urandom_range(19) != 0) begin
			nparams = $urandom_range(1, 4);
			for (int i = 0; i < nparams; i++) begin
				if (i != 0)
					send_byte(sgr_pkg::BYTE_SEMI);
				send_param();
			end
		end
		send_byte(sgr_pkg::BYTE_M);
	endtask

	task automatic send_text_run();
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(3) == 0)
				send_byte(8'($urandom_range(255)));
			else
				send_byte(8'($urandom_range(8'h20, 8'h7E)));
		end
	endtask

	task automatic send_noise();
		case ($urandom_range(2))
			0: begin
				send_byte(sgr_pkg::BYTE_ESC);
				send_byte(8'($urandom_range(255)));
			end
			1: begin
				// sequence full of arbitrary bytes, closed with 'm'
				send_byte(sgr_pkg::BYTE_ESC);
				send_byte(sgr_pkg::BYTE_LBRK);
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
				send_byte(sgr_pkg::BYTE_M);
			end
			default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
		endcase
	endtask

	initial begin
		int target;
		int r;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling.
		// plain bytes, NUL and CR dropped, top of the byte range
		send_byte("A");
		send_byte(sgr_pkg::BYTE_NUL);
		send_byte(sgr_pkg::BYTE_CR);
		send_byte(8'hFF);
		// ESC not followed by '[': both dropped, B printed
		send_byte(sgr_pkg::BYTE_ESC);
		send_string("xB");
		// '0' and ';' ignored before the first digit, then unknown code 50
		send_byte(sgr_pkg::BYTE_ESC);
		send_string("[0;50m");
		// overflowing value saturates and reports as unknown
		send_byte(sgr_pkg::BYTE_ESC);
		send_string("[9999m");
		// bold, then a parameter broken by ESC is ignored
		send_byte(sgr_pkg::BYTE_ESC);
		send_string("[1;3");
		send_byte(sgr_pkg::BYTE_ESC);
		send_string("mZ");
		// empty sequence clears everything
		send_byte(sgr_pkg::BYTE_ESC);
		send_string("[mZ");
		wait_idle();

		// Random part in four idling phases; drain between phases.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin sender_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			target = bytes_sent + RANDOM_ITEMS / 4;
			while (bytes_sent < target) begin
				r = $urandom_range(99);
				if (r < 40)
					send_text_run();
				else if (r < 85)
					send_sgr_sequence();
				else
					send_noise();
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS ansi_sgr_attribute_parser");
		else
			$display("FAIL ansi_sgr_attribute_parser");
		$finish;
	end

endmodule
